// File: rtl/erm_pkg.sv
package erm_pkg;

    localparam int CSTAGES_DEF = 16;
    localparam int XW = 33;
    localparam int ZW = 25;
    localparam logic signed [XW-1:0] GAIN_Q30 = 33'sd652032874;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } lane_t;

    typedef struct packed {
        logic           valid;
        logic [2:0]     flip;
        lane_t [2:0]    lane;
    } stage_t;

    typedef struct packed {
        logic                 flip;
        logic signed [ZW-1:0] z;
    } red_t;

    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        case (i)
            0:  return 25'sd2949120;
            1:  return 25'sd1740967;
            2:  return 25'sd919879;
            3:  return 25'sd466945;
            4:  return 25'sd234379;
            5:  return 25'sd117304;
            6:  return 25'sd58666;
            7:  return 25'sd29335;
            8:  return 25'sd14668;
            9:  return 25'sd7334;
            10: return 25'sd3667;
            11: return 25'sd1833;
            12: return 25'sd917;
            13: return 25'sd458;
            14: return 25'sd229;
            15: return 25'sd115;
            16: return 25'sd57;
            17: return 25'sd29;
            18: return 25'sd14;
            19: return 25'sd7;
            20: return 25'sd4;
            21: return 25'sd2;
            22: return 25'sd1;
            default: return 25'sd0;
        endcase
    endfunction

    // Folds an angle into [-90, +90] degrees; a fold of 180 degrees flips sine and cosine.
    function automatic red_t reduce(input logic signed [16:0] a);
        logic signed [17:0] t;
        red_t r;
        t = 18'(a);
        if (t >= 18'sd23040)
            t = t - 18'sd46080;
        else if (t < -18'sd23040)
            t = t + 18'sd46080;
        r.flip = 1'b0;
        if (t > 18'sd11520)
        begin
            t = t - 18'sd23040;
            r.flip = 1'b1;
        end
        else if (t < -18'sd11520)
        begin
            t = t + 18'sd23040;
            r.flip = 1'b1;
        end
        r.z = 25'(t) <<< 9;
        return r;
    endfunction

    function automatic logic signed [15:0] rnd_q14(input logic signed [XW-1:0] v);
        logic signed [XW:0] s;
        logic signed [XW-16:0] t;
        s = 34'(v) + 34'sd32768;
        t = 18'(s >>> 16);
        if (t > 18'sd16384)
            return ONE_Q14;
        if (t < -18'sd16384)
            return -ONE_Q14;
        return 16'(t);
    endfunction

    function automatic logic signed [15:0] rnd_entry(input logic signed [49:0] v);
        logic signed [49:0] s;
        logic signed [21:0] t;
        s = v + 50'sd134217728;
        t = 22'(s >>> 28);
        if (t > 22'sd16384)
            return ONE_Q14;
        if (t < -22'sd16384)
            return -ONE_Q14;
        return 16'(t);
    endfunction

endpackage

// File: rtl/erm_cordic_cell.sv
module erm_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  erm_pkg::stage_t din,
    output erm_pkg::stage_t dout
);
    import erm_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = atan_q16(STAGE);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    always_comb
    begin
        data_next = din;
        for (int k = 0; k < 3; k++)
        begin
            if (!din.lane[k].z[ZW-1])
            begin
                data_next.lane[k].x = din.lane[k].x - (din.lane[k].y >>> STAGE);
                data_next.lane[k].y = din.lane[k].y + (din.lane[k].x >>> STAGE);
                data_next.lane[k].z = din.lane[k].z - ATAN;
            end
            else
            begin
                data_next.lane[k].x = din.lane[k].x + (din.lane[k].y >>> STAGE);
                data_next.lane[k].y = din.lane[k].y - (din.lane[k].x >>> STAGE);
                data_next.lane[k].z = din.lane[k].z + ATAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    always_comb
    begin
        dout = data_reg;
        dout.valid = valid_reg;
    end

endmodule

// File: rtl/erm_matrix.sv
module erm_matrix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               valid,
    input  logic signed [15:0] sx,
    input  logic signed [15:0] cx,
    input  logic signed [15:0] sy,
    input  logic signed [15:0] cy,
    input  logic signed [15:0] sz,
    input  logic signed [15:0] cz,
    output logic               out_valid,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22
);
    import erm_pkg::*;

    logic [2:0] v_reg;

    logic signed [31:0] cycz_reg, cysz_reg, cxsz_reg, cxcz_reg, sxcy_reg;
    logic signed [31:0] sxsz_reg, sxcz_reg, cxcy_reg, sxsy_reg, cxsy_reg;
    logic signed [15:0] sy1_reg, cz1_reg, sz1_reg;

    logic signed [49:0] t00_reg, t01_reg, t02_reg, t12_reg, t22_reg;
    logic signed [49:0] t10a_reg, t10b_reg, t11a_reg, t11b_reg;
    logic signed [49:0] t20a_reg, t20b_reg, t21a_reg, t21b_reg;

    logic signed [15:0] m00_reg, m01_reg, m02_reg, m10_reg, m11_reg;
    logic signed [15:0] m12_reg, m20_reg, m21_reg, m22_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[1:0], valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cycz_reg <= cy * cz;
            cysz_reg <= cy * sz;
            cxsz_reg <= cx * sz;
            cxcz_reg <= cx * cz;
            sxcy_reg <= sx * cy;
            sxsz_reg <= sx * sz;
            sxcz_reg <= sx * cz;
            cxcy_reg <= cx * cy;
            sxsy_reg <= sx * sy;
            cxsy_reg <= cx * sy;
            sy1_reg  <= sy;
            cz1_reg  <= cz;
            sz1_reg  <= sz;

            // Pair products are Q.28; a factor of one more shifts them to Q.42.
            t00_reg  <= 50'(cycz_reg) <<< 14;
            t01_reg  <= -(50'(cysz_reg) <<< 14);
            t02_reg  <= 50'(sy1_reg) <<< 28;
            t10a_reg <= 50'(cxsz_reg) <<< 14;
            t10b_reg <= 50'(sxsy_reg) * 50'(cz1_reg);
            t11a_reg <= 50'(cxcz_reg) <<< 14;
            t11b_reg <= 50'(sxsy_reg) * 50'(sz1_reg);
            t12_reg  <= -(50'(sxcy_reg) <<< 14);
            t20a_reg <= 50'(sxsz_reg) <<< 14;
            t20b_reg <= 50'(cxsy_reg) * 50'(cz1_reg);
            t21a_reg <= 50'(sxcz_reg) <<< 14;
            t21b_reg <= 50'(cxsy_reg) * 50'(sz1_reg);
            t22_reg  <= 50'(cxcy_reg) <<< 14;

            m00_reg <= rnd_entry(t00_reg);
            m01_reg <= rnd_entry(t01_reg);
            m02_reg <= rnd_entry(t02_reg);
            m10_reg <= rnd_entry(t10a_reg + t10b_reg);
            m11_reg <= rnd_entry(t11a_reg - t11b_reg);
            m12_reg <= rnd_entry(t12_reg);
            m20_reg <= rnd_entry(t20a_reg - t20b_reg);
            m21_reg <= rnd_entry(t21a_reg + t21b_reg);
            m22_reg <= rnd_entry(t22_reg);
        end
    end

    assign out_valid = v_reg[2];
    assign m00 = m00_reg;
    assign m01 = m01_reg;
    assign m02 = m02_reg;
    assign m10 = m10_reg;
    assign m11 = m11_reg;
    assign m12 = m12_reg;
    assign m20 = m20_reg;
    assign m21 = m21_reg;
    assign m22 = m22_reg;

endmodule

// File: rtl/euler_rotation_matrix_unit.sv
// Euler rotation matrix unit (x-y-z order, R = Rx * Ry * Rz).
// Input channel: in_valid/in_ready with angle_x, angle_y, angle_z in degrees
// times 128, signed; any 17-bit pattern is reduced modulo 360 degrees.
// Output channel: out_valid/out_ready with the nine Q1.14 entries m00..m22,
// each saturated to plus or minus one.
// An input transfer passes through one register per CORDIC cell, one that
// rounds sine and cosine, and the three product, sum and output registers
// of the matrix stage. Throughput is one item per cycle while the receiver
// does not stall; the whole pipeline moves as one, so the row of CORDIC
// cells, each handling all three angles, sets the latency.
// When the receiver stalls with a result waiting, every stage holds and
// in_ready drops in the same cycle; in_ready is high whenever the output
// register is empty or being drained.
// Reset clears every valid bit, so the block comes up empty and ready.
module euler_rotation_matrix_unit #(
    parameter int CORDIC_STAGES = erm_pkg::CSTAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [16:0] angle_x,
    input  logic signed [16:0] angle_y,
    input  logic signed [16:0] angle_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] m00,
    output logic signed [15:0] m01,
    output logic signed [15:0] m02,
    output logic signed [15:0] m10,
    output logic signed [15:0] m11,
    output logic signed [15:0] m12,
    output logic signed [15:0] m20,
    output logic signed [15:0] m21,
    output logic signed [15:0] m22
);
    import erm_pkg::*;

    logic   adv;
    stage_t st [0:CORDIC_STAGES];
    red_t   rx, ry, rz;

    logic               rv_reg;
    logic signed [15:0] sx_reg, cx_reg, sy_reg, cy_reg, sz_reg, cz_reg;

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    assign rx = reduce(angle_x);
    assign ry = reduce(angle_y);
    assign rz = reduce(angle_z);

    always_comb
    begin
        st[0].valid = in_valid && in_ready;
        st[0].flip  = {rz.flip, ry.flip, rx.flip};
        st[0].lane[0] = '{x: GAIN_Q30, y: '0, z: rx.z};
        st[0].lane[1] = '{x: GAIN_Q30, y: '0, z: ry.z};
        st[0].lane[2] = '{x: GAIN_Q30, y: '0, z: rz.z};
    end

    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_cell
        erm_cordic_cell #(.STAGE(g)) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .en   (adv),
            .din  (st[g]),
            .dout (st[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg <= 1'b0;
        else if (adv)
            rv_reg <= st[CORDIC_STAGES].valid;
    end

    // A folded angle negates both sine and cosine after rounding.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg <= st[CORDIC_STAGES].flip[0] ? -rnd_q14(st[CORDIC_STAGES].lane[0].x)
                                                :  rnd_q14(st[CORDIC_STAGES].lane[0].x);
            sx_reg <= st[CORDIC_STAGES].flip[0] ? -rnd_q14(st[CORDIC_STAGES].lane[0].y)
                                                :  rnd_q14(st[CORDIC_STAGES].lane[0].y);
            cy_reg <= st[CORDIC_STAGES].flip[1] ? -rnd_q14(st[CORDIC_STAGES].lane[1].x)
                                                :  rnd_q14(st[CORDIC_STAGES].lane[1].x);
            sy_reg <= st[CORDIC_STAGES].flip[1] ? -rnd_q14(st[CORDIC_STAGES].lane[1].y)
                                                :  rnd_q14(st[CORDIC_STAGES].lane[1].y);
            cz_reg <= st[CORDIC_STAGES].flip[2] ? -rnd_q14(st[CORDIC_STAGES].lane[2].x)
                                                :  rnd_q14(st[CORDIC_STAGES].lane[2].x);
            sz_reg <= st[CORDIC_STAGES].flip[2] ? -rnd_q14(st[CORDIC_STAGES].lane[2].y)
                                                :  rnd_q14(st[CORDIC_STAGES].lane[2].y);
        end
    end

    erm_matrix u_matrix (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .valid    (rv_reg),
        .sx       (sx_reg),
        .cx       (cx_reg),
        .sy       (sy_reg),
        .cy       (cy_reg),
        .sz       (sz_reg),
        .cz       (cz_reg),
        .out_valid(out_valid),
        .m00      (m00),
        .m01      (m01),
        .m02      (m02),
        .m10      (m10),
        .m11      (m11),
        .m12      (m12),
        .m20      (m20),
        .m21      (m21),
        .m22      (m22)
    );

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow the output register state");

    a_m00_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (m00 <= 16'sd16384 && m00 >= -16'sd16384))
        else $error("m00 outside saturation range");

    a_m11_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (m11 <= 16'sd16384 && m11 >= -16'sd16384))
        else $error("m11 outside saturation range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(m10) && $stable(m21)))
        else $error("result changed while the receiver stalled");

endmodule

// File: sim/euler_rotation_matrix_unit_tb.sv
module euler_rotation_matrix_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = erm_pkg::CSTAGES_DEF;
    localparam int LATENCY = STAGES + 4;
    localparam int ANG_FULL = 46080;
    localparam int ANG_HALF = 23040;
    localparam int ANG_QUARTER = 11520;
    localparam int ANG_MAX = 46080;

    typedef struct {
        logic signed [15:0] e [9];
    } matrix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [16:0] angle_x = '0;
    logic signed [16:0] angle_y = '0;
    logic signed [16:0] angle_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

    matrix_t expected_matrices[$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off_cycles = 0;

    euler_rotation_matrix_unit #(.CORDIC_STAGES(STAGES)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11),
        .m12(m12), .m20(m20), .m21(m21), .m22(m22)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint floor_div_pow2(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint clamp_unit(longint v);
        if (v > 16384)
            return 16384;
        if (v < -16384)
            return -16384;
        return v;
    endfunction

    function automatic longint arctan_step(int i);
        longint tbl [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
            58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
            57, 29, 14, 7, 4, 2, 1, 0};
        return tbl[i];
    endfunction

    task automatic sine_cosine(input logic signed [16:0] ang, output longint s,
                               output longint c);
        longint a, x, y, z, xs, ys;
        bit flip;
        a = longint'(ang) % ANG_FULL;
        flip = 1'b0;
        if (a < 0)
            a += ANG_FULL;
        if (a >= ANG_HALF)
            a -= ANG_FULL;
        if (a > ANG_QUARTER)
        begin
            a -= ANG_HALF;
            flip = 1'b1;
        end
        else if (a < -ANG_QUARTER)
        begin
            a += ANG_HALF;
            flip = 1'b1;
        end
        x = 652032874;
        y = 0;
        z = a * 512;
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            xs = floor_div_pow2(x, i);
            ys = floor_div_pow2(y, i);
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= arctan_step(i);
            end
            else
            begin
                x += ys;
                y -= xs;
                z += arctan_step(i);
            end
        end
        c = clamp_unit(floor_div_pow2(x + 32768, 16));
        s = clamp_unit(floor_div_pow2(y + 32768, 16));
        if (flip)
        begin
            c = -c;
            s = -s;
        end
    endtask

    function automatic logic signed [15:0] round_entry(longint v);
        return 16'(clamp_unit(floor_div_pow2(v + (64'sd1 <<< 27), 28)));
    endfunction

    task automatic predict_rotation(input logic signed [16:0] ax, ay, az,
                                    output matrix_t m);
        longint sx, cx, sy, cy, sz, cz;
        longint k;
        k = 16384;
        sine_cosine(ax, sx, cx);
        sine_cosine(ay, sy, cy);
        sine_cosine(az, sz, cz);
        m.e[0] = round_entry(cy * cz * k);
        m.e[1] = round_entry(-(cy * sz * k));
        m.e[2] = round_entry(sy * k * k);
        m.e[3] = round_entry(cx * sz * k + sx * sy * cz);
        m.e[4] = round_entry(cx * cz * k - sx * sy * sz);
        m.e[5] = round_entry(-(sx * cy * k));
        m.e[6] = round_entry(sx * sz * k - cx * sy * cz);
        m.e[7] = round_entry(sx * cz * k + cx * sy * sz);
        m.e[8] = round_entry(cx * cy * k);
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        $display("ERROR at %0t: %s", $realtime, what);
    endtask

    // Sends one angle triple and records its expected matrix on transfer.
    // The caller drops in_valid once it stops sending.
    task automatic send_angles(input logic signed [16:0] ax, ay, az);
        matrix_t m;
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        angle_x <= ax;
        angle_y <= ay;
        angle_z <= az;
        predict_rotation(ax, ay, az, m);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_matrices.push_back(m);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (expected_matrices.size() != 0 && guard < 100000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            out_ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        matrix_t want;
        logic signed [15:0] got [9];
        if (rst_n && out_valid && out_ready)
        begin
            got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
            if (expected_matrices.size() == 0)
                report_mismatch("result with no expected matrix");
            else
            begin
                want = expected_matrices.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got[i] !== want.e[i])
                        report_mismatch($sformatf("m%0d%0d got %0d expected %0d",
                            i / 3, i % 3, got[i], want.e[i]));
            end
        end
    end

    function automatic logic signed [16:0] any_angle();
        return 17'($urandom);
    endfunction

    function automatic logic signed [16:0] legal_angle();
        return 17'($urandom_range(2 * ANG_MAX, 0) - ANG_MAX);
    endfunction

    task automatic test_directed();
        int pts [12] = '{0, 11520, -11520, 23040, -23040, 46080, -46080,
            11521, -11521, 23039, 65535, -65536};
        foreach (pts[i])
            send_angles(17'(pts[i]), 17'(pts[(i + 3) % 12]), 17'(pts[(i + 7) % 12]));
        send_angles(17'h0FFFF, 17'h10000, 17'h1FFFF);
        send_angles(17'h10000, 17'h0FFFF, 17'h00001);
        send_angles(17'h15555, 17'h0AAAA, 17'h1FFFF);
        send_angles(17'h0AAAA, 17'h15555, 17'h00000);
        send_angles(17'd5760, 17'd5760, 17'd5760);
        send_angles(-17'sd5760, 17'd17280, -17'sd17280);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            if ($urandom_range(9, 0) == 0)
                send_angles(any_angle(), any_angle(), any_angle());
            else
                send_angles(legal_angle(), legal_angle(), legal_angle());
    endtask

    // The receiver holds off long enough to fill the pipeline and stall input.
    task automatic test_backpressure();
        in_valid <= 1'b0;
        @(posedge clk);
        hold_off_cycles <= 3 * LATENCY;
        test_random(4 * LATENCY);
        wait_drained();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        send_idle_pct = 22;
        recv_idle_pct = 75;
        test_random(650);
        wait_drained();
        send_idle_pct = 75;
        recv_idle_pct = 22;
        test_random(650);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(650);
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (expected_matrices.size() != 0)
            report_mismatch("expected matrices left over");
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/erm_pkg.sv
rtl/erm_cordic_cell.sv
rtl/erm_matrix.sv
rtl/euler_rotation_matrix_unit.sv
sim/euler_rotation_matrix_unit_tb.sv
